[design/wtra_pkg.sv]
// ----------------------------------------------------------------------------
// wtra_pkg: shared definitions for the word to radix ascii formatter
// word width, digit counts, radix codes, character codes and digit mapping
// ----------------------------------------------------------------------------
package wtra_pkg;

    localparam int WORD_BITS  = 32;
    localparam int VALUE_BITS = 32;

    // digit counts of a full word in each radix
    localparam int BIN_DIGITS = WORD_BITS;
    localparam int OCT_DIGITS = (WORD_BITS + 2) / 3;
    localparam int HEX_DIGITS = (WORD_BITS + 3) / 4;
    localparam int DEC_DIGITS = (WORD_BITS * 302) / 1000 + 1;
    localparam int BCD_BITS   = DEC_DIGITS * 4;

    // wide enough to count every digit of the longest radix
    localparam int DCNT_BITS  = $clog2(WORD_BITS + 1);

    localparam logic [1:0] FUNC_BIN = 2'd0;
    localparam logic [1:0] FUNC_OCT = 2'd1;
    localparam logic [1:0] FUNC_DEC = 2'd2;
    localparam logic [1:0] FUNC_HEX = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_O     = 8'h6f;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_NL    = 8'h0a;

    typedef struct packed {
        logic [1:0] func;
        logic       neg;
    } emit_cmd_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + {4'd0, d};
        end
        else
        begin
            c = CH_A + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

[design/wtra_dabble.sv]
// ----------------------------------------------------------------------------
// wtra_dabble: bit-serial binary to bcd converter
// shifts the word in one bit per cycle, adjusting each bcd digit on the way
// ----------------------------------------------------------------------------
module wtra_dabble (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [wtra_pkg::WORD_BITS-1:0]   word,
    output logic                             done,
    output logic [wtra_pkg::BCD_BITS-1:0]    bcd
);

    logic [wtra_pkg::WORD_BITS-1:0] bin_reg, bin_next;
    logic [wtra_pkg::BCD_BITS-1:0]  bcd_reg, bcd_next;
    logic [wtra_pkg::DCNT_BITS-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [wtra_pkg::BCD_BITS-1:0]  adj;

    always_comb
    begin
        logic [3:0] dg;
        dg = 4'd0;
        // add three to every digit of five or more before the shift
        for (int i = 0; i < wtra_pkg::DEC_DIGITS; i++)
        begin
            dg = bcd_reg[i*4 +: 4];
            adj[i*4 +: 4] = (dg >= 4'd5) ? dg + 4'd3 : dg;
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = word;
            bcd_next  = '0;
            cnt_next  = wtra_pkg::DCNT_BITS'(wtra_pkg::WORD_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[wtra_pkg::BCD_BITS-2:0], bin_reg[wtra_pkg::WORD_BITS-1]};
            bin_next = bin_reg << 1;
            cnt_next = cnt_reg - wtra_pkg::DCNT_BITS'(1);
            if (cnt_reg == wtra_pkg::DCNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

[design/wtra_emit.sv]
// ----------------------------------------------------------------------------
// wtra_emit: character sequencer
// sends sign, prefix, digits and newline one character per request
// ----------------------------------------------------------------------------
module wtra_emit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  wtra_pkg::emit_cmd_t             cmd,
    input  logic [wtra_pkg::BCD_BITS-1:0]   digits,
    output logic                            done,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      char_out,
    output logic                            last
);

    localparam int SHR_BITS  = wtra_pkg::BCD_BITS;
    localparam int BIN_SHIFT = SHR_BITS - wtra_pkg::BIN_DIGITS;
    localparam int OCT_SHIFT = SHR_BITS - 3 * wtra_pkg::OCT_DIGITS;
    localparam int HEX_SHIFT = SHR_BITS - 4 * wtra_pkg::HEX_DIGITS;

    localparam logic [2:0] E_IDLE = 3'd0;
    localparam logic [2:0] E_SIGN = 3'd1;
    localparam logic [2:0] E_PFX0 = 3'd2;
    localparam logic [2:0] E_PFX1 = 3'd3;
    localparam logic [2:0] E_DIG  = 3'd4;
    localparam logic [2:0] E_NL   = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [SHR_BITS-1:0]            shr_reg, shr_next;
    logic [wtra_pkg::DCNT_BITS-1:0] cnt_reg, cnt_next;
    logic [1:0]                     func_reg, func_next;
    logic                           started_reg, started_next;
    logic                           ovalid_reg, ovalid_next;
    logic [7:0]                     char_reg, char_next;
    logic                           last_reg, last_next;

    logic                           adv;
    logic                           load;
    logic [SHR_BITS-1:0]            shr_load;
    logic [wtra_pkg::DCNT_BITS-1:0] cnt_load;
    logic [3:0]                     dig;
    logic [SHR_BITS-1:0]            shr_shift;
    logic [7:0]                     pfx_char;

    // output register free or being emptied this cycle
    assign adv = !ovalid_reg || !out_stall;

    // first digit lined up at the top of the shift register
    always_comb
    begin
        case (cmd.func)
            wtra_pkg::FUNC_BIN:
            begin
                shr_load = digits << BIN_SHIFT;
                cnt_load = wtra_pkg::DCNT_BITS'(wtra_pkg::BIN_DIGITS);
            end
            wtra_pkg::FUNC_OCT:
            begin
                shr_load = digits << OCT_SHIFT;
                cnt_load = wtra_pkg::DCNT_BITS'(wtra_pkg::OCT_DIGITS);
            end
            wtra_pkg::FUNC_HEX:
            begin
                shr_load = digits << HEX_SHIFT;
                cnt_load = wtra_pkg::DCNT_BITS'(wtra_pkg::HEX_DIGITS);
            end
            default:
            begin
                shr_load = digits;
                cnt_load = wtra_pkg::DCNT_BITS'(wtra_pkg::DEC_DIGITS);
            end
        endcase
    end

    always_comb
    begin
        case (func_reg)
            wtra_pkg::FUNC_BIN:
            begin
                dig       = {3'd0, shr_reg[SHR_BITS-1]};
                shr_shift = shr_reg << 1;
                pfx_char  = wtra_pkg::CH_B;
            end
            wtra_pkg::FUNC_OCT:
            begin
                dig       = {1'b0, shr_reg[SHR_BITS-1 -: 3]};
                shr_shift = shr_reg << 3;
                pfx_char  = wtra_pkg::CH_O;
            end
            default:
            begin
                dig       = shr_reg[SHR_BITS-1 -: 4];
                shr_shift = shr_reg << 4;
                pfx_char  = wtra_pkg::CH_X;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        shr_next     = shr_reg;
        cnt_next     = cnt_reg;
        func_next    = func_reg;
        started_next = started_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        load         = 1'b0;
        done         = 1'b0;
        case (state_reg)
            E_IDLE:
            begin
                if (start)
                begin
                    shr_next     = shr_load;
                    cnt_next     = cnt_load;
                    func_next    = cmd.func;
                    started_next = 1'b0;
                    if (cmd.func != wtra_pkg::FUNC_DEC)
                        state_next = E_PFX0;
                    else if (cmd.neg)
                        state_next = E_SIGN;
                    else
                        state_next = E_DIG;
                end
            end
            E_SIGN:
            begin
                if (adv)
                begin
                    load       = 1'b1;
                    char_next  = wtra_pkg::CH_MINUS;
                    last_next  = 1'b0;
                    state_next = E_DIG;
                end
            end
            E_PFX0:
            begin
                if (adv)
                begin
                    load       = 1'b1;
                    char_next  = wtra_pkg::CH_ZERO;
                    last_next  = 1'b0;
                    state_next = E_PFX1;
                end
            end
            E_PFX1:
            begin
                if (adv)
                begin
                    load       = 1'b1;
                    char_next  = pfx_char;
                    last_next  = 1'b0;
                    state_next = E_DIG;
                end
            end
            E_DIG:
            begin
                // leading zero skipped, the final digit always goes out
                if (dig == 4'd0 && !started_reg && cnt_reg != wtra_pkg::DCNT_BITS'(1))
                begin
                    shr_next = shr_shift;
                    cnt_next = cnt_reg - wtra_pkg::DCNT_BITS'(1);
                end
                else if (adv)
                begin
                    load         = 1'b1;
                    char_next    = wtra_pkg::digit_char(dig);
                    last_next    = 1'b0;
                    started_next = 1'b1;
                    shr_next     = shr_shift;
                    cnt_next     = cnt_reg - wtra_pkg::DCNT_BITS'(1);
                    if (cnt_reg == wtra_pkg::DCNT_BITS'(1))
                        state_next = E_NL;
                end
            end
            E_NL:
            begin
                if (adv)
                begin
                    load       = 1'b1;
                    char_next  = wtra_pkg::CH_NL;
                    last_next  = 1'b1;
                    done       = 1'b1;
                    state_next = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load)
            ovalid_next = 1'b1;
        else if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= E_IDLE;
            ovalid_reg  <= 1'b0;
            started_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ovalid_reg  <= ovalid_next;
            started_reg <= started_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shr_reg  <= shr_next;
        func_reg <= func_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = ovalid_reg;
    assign char_out  = char_reg;
    assign last      = last_reg;

endmodule

[design/word_to_radix_ascii.sv]
// ----------------------------------------------------------------------------
// word_to_radix_ascii: formats a word as ascii text in binary, octal,
// decimal or hex, one character per output request
// ----------------------------------------------------------------------------
// One word is in flight at a time. A binary, octal or hex word goes straight
// to the character sequencer; a decimal word first passes through the
// bit-serial bcd converter. The sequencer then sends the characters (sign,
// prefix, digits, newline) as the output register frees and skips each
// leading zero in turn; the full digit count of the radix is 8, 11, 32 or 10
// at 32 bits (hex, octal, binary, decimal). Output stalls hold the sequencer.
// The next word is taken the cycle after the newline reaches the output
// register.
// ----------------------------------------------------------------------------
module word_to_radix_ascii (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] value,
    input  logic [1:0]  func,
    input  logic        signed_mode,
    input  logic        swap_bytes,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  char_out,
    output logic        last
);

    localparam int WB = wtra_pkg::WORD_BITS;
    localparam int NB = WB / 8;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                    state_reg, state_next;
    logic                          neg_reg, neg_next;

    logic                          accept;
    logic [WB-1:0]                 w_in;
    logic [WB-1:0]                 w_sw;
    logic [WB-1:0]                 mag;
    logic                          neg;
    logic                          is_dec;

    logic                          dab_start;
    logic                          dab_done;
    logic [wtra_pkg::BCD_BITS-1:0] bcd;

    logic                          emit_start;
    logic                          emit_done;
    wtra_pkg::emit_cmd_t           emit_cmd;
    logic [wtra_pkg::BCD_BITS-1:0] emit_digits;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign is_dec   = (func == wtra_pkg::FUNC_DEC);

    assign w_in = WB'(value);

    always_comb
    begin
        for (int b = 0; b < NB; b++)
        begin
            w_sw[b*8 +: 8] = swap_bytes ? w_in[(NB-1-b)*8 +: 8] : w_in[b*8 +: 8];
        end
    end

    // signed decimal prints the magnitude after a minus sign
    assign neg = is_dec && signed_mode && w_sw[WB-1];
    assign mag = neg ? (~w_sw + WB'(1)) : w_sw;

    always_comb
    begin
        state_next  = state_reg;
        neg_next    = neg_reg;
        dab_start   = 1'b0;
        emit_start  = 1'b0;
        emit_cmd    = '{func: func, neg: 1'b0};
        emit_digits = wtra_pkg::BCD_BITS'(mag);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next = neg;
                    if (is_dec)
                    begin
                        dab_start  = 1'b1;
                        state_next = ST_CONV;
                    end
                    else
                    begin
                        emit_start = 1'b1;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_CONV:
            begin
                emit_cmd    = '{func: wtra_pkg::FUNC_DEC, neg: neg_reg};
                emit_digits = bcd;
                if (dab_done)
                begin
                    emit_start = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
    end

    wtra_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dab_start),
        .word  (mag),
        .done  (dab_done),
        .bcd   (bcd)
    );

    wtra_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (emit_start),
        .cmd       (emit_cmd),
        .digits    (emit_digits),
        .done      (emit_done),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_out  (char_out),
        .last      (last)
    );

endmodule

[design/wtra_checker.sv]
// ----------------------------------------------------------------------------
// wtra_checker: port-level checks for the radix formatter
// watches both channels and the framing of each text run
// ----------------------------------------------------------------------------
module wtra_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] char_out,
    input logic       last
);

    // a stalled character holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_out) && $stable(last))
        else $error("stalled output character changed");

    // the run closes on a newline
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> char_out == wtra_pkg::CH_NL)
        else $error("last marker on a character other than newline");

    // a newline never appears inside a run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_out == wtra_pkg::CH_NL |-> last)
        else $error("newline without last marker");

    // one word at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not held off after a request");

endmodule

bind word_to_radix_ascii wtra_checker u_checker (.*);

[tb/tb_word_to_radix_ascii.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_word_to_radix_ascii: self-checking bench for the radix ascii formatter
// Every accepted word request is turned into its expected character stream
// (sign, prefix, digits, newline) and each character leaving the block is
// compared against the oldest expected one. Both sides idle at random in the
// first two of three phases of sender and receiver pressure; the third has no idling.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [7:0] ch;
    logic       fin;
} text_char_t;

class text_tracker;
    text_char_t pending_chars[$];
    int         errors = 0;

    // builds the text of one word request and queues its characters
    function void note_word(logic [31:0] v, logic [1:0] f, logic sgn, logic swp);
        logic [wtra_pkg::WORD_BITS-1:0] raw;
        logic [wtra_pkg::WORD_BITS-1:0] w;
        logic [7:0]                     digs[$];
        longint unsigned                mag;
        longint unsigned                base;
        int unsigned                    d;
        raw = v[wtra_pkg::WORD_BITS-1:0];
        w = raw;
        if (swp)
        begin
            for (int k = 0; k < wtra_pkg::WORD_BITS / 8; k++)
            begin
                w[8*k +: 8] = raw[wtra_pkg::WORD_BITS-8-8*k +: 8];
            end
        end
        if (f == wtra_pkg::FUNC_DEC)
        begin
            base = 10;
            if (sgn && w[wtra_pkg::WORD_BITS-1])
            begin
                pending_chars.push_back(text_char_t'{wtra_pkg::CH_MINUS, 1'b0});
                w = -w;
            end
        end
        else
        begin
            pending_chars.push_back(text_char_t'{wtra_pkg::CH_ZERO, 1'b0});
            case (f)
                wtra_pkg::FUNC_BIN:
                begin
                    pending_chars.push_back(text_char_t'{wtra_pkg::CH_B, 1'b0});
                    base = 2;
                end
                wtra_pkg::FUNC_OCT:
                begin
                    pending_chars.push_back(text_char_t'{wtra_pkg::CH_O, 1'b0});
                    base = 8;
                end
                default:
                begin
                    pending_chars.push_back(text_char_t'{wtra_pkg::CH_X, 1'b0});
                    base = 16;
                end
            endcase
        end
        mag = w;
        do
        begin
            d = 32'(mag % base);
            if (d < 10)
                digs.push_front(wtra_pkg::CH_ZERO + 8'(d));
            else
                digs.push_front(wtra_pkg::CH_A + 8'(d - 10));
            mag = mag / base;
        end
        while (mag != 0);
        foreach (digs[i])
        begin
            pending_chars.push_back(text_char_t'{digs[i], 1'b0});
        end
        pending_chars.push_back(text_char_t'{wtra_pkg::CH_NL, 1'b1});
    endfunction

    function void check_char(logic [7:0] ch, logic fin);
        text_char_t exp_c;
        if (pending_chars.size() == 0)
        begin
            $error("char_out with nothing expected: actual %h last %b", ch, fin);
            errors++;
            return;
        end
        exp_c = pending_chars.pop_front();
        if (ch !== exp_c.ch)
        begin
            $error("char_out mismatch: expected %h actual %h", exp_c.ch, ch);
            errors++;
        end
        if (fin !== exp_c.fin)
        begin
            $error("last mismatch: expected %b actual %b", exp_c.fin, fin);
            errors++;
        end
    endfunction

    function int pending();
        return pending_chars.size();
    endfunction
endclass

module tb_word_to_radix_ascii;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_WORDS = 82;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] value = '0;
    logic [1:0]  func = wtra_pkg::FUNC_BIN;
    logic        signed_mode = 1'b0;
    logic        swap_bytes = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  char_out;
    logic        last;

    int          send_idle = 38;
    int          recv_idle = 64;
    int          cycles = 0;
    text_tracker board = new();

    word_to_radix_ascii uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .func        (func),
        .signed_mode (signed_mode),
        .swap_bytes  (swap_bytes),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .char_out    (char_out),
        .last        (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_idle);
    end

    // everything settles at the rising edge, so the values here hold at the next one
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_char(char_out, last);
    end

    // called at a rising edge; returns at the edge that takes the request
    task automatic send_word(input logic [31:0] v, input logic [1:0] f,
                             input logic sgn, input logic swp);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        func <= f;
        signed_mode <= sgn;
        swap_bytes <= swp;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        board.note_word(v, f, sgn, swp);
    endtask

    task automatic send_random_words(input int n);
        logic [31:0] v;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(5))
                0: v = $urandom;
                1: v = $urandom_range(0, 255);
                2: v = 32'h1 << $urandom_range(31);
                3: v = 32'hffff_ffff >> $urandom_range(31);
                4: v = {1'b1, 31'($urandom)};
                default: v = $urandom & $urandom;
            endcase
            send_word(v, 2'($urandom_range(3)), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // zero in every radix
        send_word(32'h0, wtra_pkg::FUNC_BIN, 1'b0, 1'b0);
        send_word(32'h0, wtra_pkg::FUNC_OCT, 1'b0, 1'b0);
        send_word(32'h0, wtra_pkg::FUNC_DEC, 1'b1, 1'b0);
        send_word(32'h0, wtra_pkg::FUNC_HEX, 1'b0, 1'b1);
        // all ones, longest text per radix, and all ones as signed decimal
        send_word(32'hffff_ffff, wtra_pkg::FUNC_BIN, 1'b0, 1'b0);
        send_word(32'hffff_ffff, wtra_pkg::FUNC_OCT, 1'b0, 1'b0);
        send_word(32'hffff_ffff, wtra_pkg::FUNC_DEC, 1'b0, 1'b0);
        send_word(32'hffff_ffff, wtra_pkg::FUNC_HEX, 1'b0, 1'b0);
        send_word(32'hffff_ffff, wtra_pkg::FUNC_DEC, 1'b1, 1'b0);
        // most negative word and its neighbours
        send_word(32'h8000_0000, wtra_pkg::FUNC_DEC, 1'b1, 1'b0);
        send_word(32'h8000_0000, wtra_pkg::FUNC_DEC, 1'b0, 1'b0);
        send_word(32'h7fff_ffff, wtra_pkg::FUNC_DEC, 1'b1, 1'b0);
        send_word(32'h0000_0080, wtra_pkg::FUNC_DEC, 1'b1, 1'b1);
        // sign flag ignored outside decimal
        send_word(32'h8000_0001, wtra_pkg::FUNC_BIN, 1'b1, 1'b0);
        send_word(32'hc000_0000, wtra_pkg::FUNC_OCT, 1'b1, 1'b0);
        send_word(32'hdead_beef, wtra_pkg::FUNC_HEX, 1'b1, 1'b0);
        // byte swap
        send_word(32'h1234_5678, wtra_pkg::FUNC_HEX, 1'b0, 1'b1);
        send_word(32'h0000_0001, wtra_pkg::FUNC_BIN, 1'b0, 1'b1);
        send_word(32'h0102_0304, wtra_pkg::FUNC_OCT, 1'b0, 1'b1);
        // single digits and a decimal power of ten
        send_word(32'h1, wtra_pkg::FUNC_BIN, 1'b0, 1'b0);
        send_word(32'h7, wtra_pkg::FUNC_OCT, 1'b0, 1'b0);
        send_word(32'd9, wtra_pkg::FUNC_DEC, 1'b1, 1'b0);
        send_word(32'ha, wtra_pkg::FUNC_HEX, 1'b0, 1'b0);
        send_word(32'd1000000000, wtra_pkg::FUNC_DEC, 1'b1, 1'b0);

        send_random_words(PHASE_WORDS);
        send_idle = 64;
        recv_idle = 38;
        send_random_words(PHASE_WORDS);
        send_idle = 0;
        recv_idle = 0;
        send_random_words(PHASE_WORDS);
        in_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
